FILE: rtl/pgcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgcb_pkg;

	// sample and register formats
	localparam int PIX_W     = 8;
	localparam int REG_BITS  = 10;
	localparam int CFG_IDX_W = 2;

	// power values are q30, one integer bit on top
	localparam int Q_FRAC = 30;
	localparam int P_W    = Q_FRAC + 1;

	// transfer table, one entry per sample code
	localparam int TBL_AW    = PIX_W;
	localparam int TBL_DEPTH = 1 << TBL_AW;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CONTRAST = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT   = CFG_IDX_W'(2);

	localparam logic [P_W-1:0] Q_ONE  = P_W'(1) << Q_FRAC;
	localparam logic [P_W-1:0] Q_HALF = P_W'(1) << (Q_FRAC - 1);

	// x = (v * 2^30 + 127) / 255 stepped over v: 2^30 = 255 * X_STEP_Q + X_STEP_R
	localparam int X_DIV    = 255;
	localparam int X_STEP_Q = 4210752;
	localparam int X_STEP_R = 64;
	localparam int X_INIT_R = 127;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [P_W-1:0]   pval_t;

	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] addr;
		pval_t             data;
	} tbl_wr_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} adv_t;

endpackage

`default_nettype wire

FILE: rtl/pgcb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pgcb_ram #(
	parameter int DW    = 32,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/pgcb_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// floor(sqrt(a * 2^30)) on a q30 operand, one result bit per cycle
module pgcb_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pgcb_pkg::pval_t a,
	output logic            done,
	output pgcb_pkg::pval_t root
);
	import pgcb_pkg::*;

	localparam int RW = 2 * P_W;

	logic [RW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [RW-1:0] bit_q;
	logic [RW-1:0] trial_c;
	logic          busy_q;
	logic          done_q;

	assign trial_c = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= RW'(a) << Q_FRAC;
			root_q <= '0;
			bit_q  <= RW'(1) << (2 * Q_FRAC);
		end else if (busy_q) begin
			if (rem_q >= trial_c) begin
				rem_q  <= rem_q - trial_c;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[P_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/pgcb_table.sv
`timescale 1ns / 1ps
`default_nettype none

// fills the power table x^(g/2^f) for every sample code, one entry at a time
module pgcb_table #(
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pgcb_pkg::REG_BITS-1:0]   gamma,
	input  logic                            rebuild,
	output logic                            busy,
	output pgcb_pkg::tbl_wr_t               tbl_wr
);
	import pgcb_pkg::*;

	localparam int JW   = $clog2(COEF_FRAC_BITS);
	localparam int KW   = $clog2(REG_BITS);
	localparam int MW   = 2 * P_W;
	localparam int XR_W = 9;

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_INIT  = 3'd1;
	localparam logic [2:0] B_ENTRY = 3'd2;
	localparam logic [2:0] B_SQRT  = 3'd3;
	localparam logic [2:0] B_MUL   = 3'd4;
	localparam logic [2:0] B_WRITE = 3'd5;

	function automatic pval_t qmul(input pval_t op_a, input pval_t op_b);
		logic [MW-1:0] m;
		m = MW'(op_a) * MW'(op_b) + MW'(Q_HALF);
		return m[Q_FRAC+P_W-1:Q_FRAC];
	endfunction

	logic [2:0]        state_q;
	logic [TBL_AW-1:0] v_q;
	logic [JW-1:0]     j_q;
	logic [KW-1:0]     k_q;
	pval_t             xq_q;
	logic [XR_W-1:0]   xr_q;
	pval_t             acc_q;
	pval_t             sq_q;
	pval_t             s_q [COEF_FRAC_BITS];

	logic              sq_start;
	pval_t             sq_a;
	logic              sq_done;
	pval_t             sq_root;
	logic              k_lt_f;
	pval_t             fac_c;
	logic [XR_W-1:0]   xr_sum;

	// each root feeds the next, so the chain starts from x and works downwards
	assign sq_start = (state_q == B_ENTRY) ||
		((state_q == B_SQRT) && sq_done && (j_q != JW'(COEF_FRAC_BITS - 1)));
	assign sq_a = (state_q == B_ENTRY) ? xq_q : sq_root;

	pgcb_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.a     (sq_a),
		.done  (sq_done),
		.root  (sq_root)
	);

	// fractional exponent bits take a root, integer bits a repeated square
	assign k_lt_f = int'(k_q) < COEF_FRAC_BITS;
	assign fac_c  = k_lt_f ? s_q[j_q] : sq_q;
	assign xr_sum = xr_q + XR_W'(X_STEP_R);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			v_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else if (rebuild) begin
			state_q <= B_INIT;
		end else begin
			case (state_q)
				B_IDLE: begin
					state_q <= B_IDLE;
				end
				B_INIT: begin
					v_q     <= '0;
					state_q <= B_ENTRY;
				end
				B_ENTRY: begin
					j_q     <= '0;
					k_q     <= '0;
					state_q <= B_SQRT;
				end
				B_SQRT: begin
					if (sq_done) begin
						if (j_q == JW'(COEF_FRAC_BITS - 1)) begin
							state_q <= B_MUL;
						end else begin
							j_q <= j_q + JW'(1);
						end
					end
				end
				B_MUL: begin
					if (j_q != '0) begin
						j_q <= j_q - JW'(1);
					end
					if (k_q == KW'(REG_BITS - 1)) begin
						state_q <= B_WRITE;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				B_WRITE: begin
					if (v_q == '1) begin
						state_q <= B_IDLE;
					end else begin
						v_q     <= v_q + TBL_AW'(1);
						state_q <= B_ENTRY;
					end
				end
				default: begin
					state_q <= B_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_INIT: begin
				xq_q <= '0;
				xr_q <= XR_W'(X_INIT_R);
			end
			B_ENTRY: begin
				acc_q <= Q_ONE;
				sq_q  <= xq_q;
			end
			B_SQRT: begin
				if (sq_done) begin
					s_q[j_q] <= sq_root;
				end
			end
			B_MUL: begin
				if (gamma[k_q]) begin
					acc_q <= qmul(acc_q, fac_c);
				end
				if (!k_lt_f) begin
					sq_q <= qmul(sq_q, sq_q);
				end
			end
			B_WRITE: begin
				if (xr_sum >= XR_W'(X_DIV)) begin
					xr_q <= xr_sum - XR_W'(X_DIV);
					xq_q <= xq_q + P_W'(X_STEP_Q + 1);
				end else begin
					xr_q <= xr_sum;
					xq_q <= xq_q + P_W'(X_STEP_Q);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = state_q != B_IDLE;
	assign tbl_wr.we   = state_q == B_WRITE;
	assign tbl_wr.addr = v_q;
	assign tbl_wr.data = acc_q;

endmodule

`default_nettype wire

FILE: rtl/pgcb_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// one colour channel: table lookup, gain, offset, rescale, round and clamp
module pgcb_lane #(
	parameter int COEF_FRAC_BITS = 8,
	localparam int GAIN_W = (COEF_FRAC_BITS + 1 > pgcb_pkg::REG_BITS) ?
		COEF_FRAC_BITS + 1 : pgcb_pkg::REG_BITS
) (
	input  logic                                 clk,
	input  pgcb_pkg::adv_t                       adv,
	input  pgcb_pkg::tbl_wr_t                    tbl_wr,
	input  pgcb_pkg::pix_t                       chan,
	input  logic [GAIN_W-1:0]                    gain,
	input  logic signed [pgcb_pkg::REG_BITS-1:0] bright,
	output pgcb_pkg::pix_t                       result
);
	import pgcb_pkg::*;

	localparam int PROD_W = GAIN_W + P_W;
	localparam int S_W    = PROD_W + 2;
	localparam int T_W    = S_W + PIX_W + 1;
	localparam int SH     = Q_FRAC + COEF_FRAC_BITS;
	localparam logic signed [T_W-1:0] RND = T_W'(1) << (SH - 1);

	pval_t                   p_s1;
	logic [PROD_W-1:0]       prod_s2;
	logic signed [S_W-1:0]   sum_s3;
	logic signed [S_W-1:0]   bright_c;
	logic signed [T_W-1:0]   sum_ext;
	logic signed [T_W-1:0]   t_c;

	pgcb_ram #(
		.DW   (P_W),
		.DEPTH(TBL_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (tbl_wr.we),
		.waddr(tbl_wr.addr),
		.wdata(tbl_wr.data),
		.re   (adv.en1),
		.raddr(chan),
		.rdata(p_s1)
	);

	assign bright_c = S_W'(bright);

	always_ff @(posedge clk) begin
		if (adv.en2) begin
			prod_s2 <= PROD_W'(gain) * PROD_W'(p_s1);
		end
		if (adv.en3) begin
			sum_s3 <= signed'({2'b00, prod_s2}) + (bright_c <<< Q_FRAC);
		end
	end

	// times 255 as shift and subtract, then round half up
	assign sum_ext = T_W'(sum_s3);
	assign t_c     = (sum_ext <<< PIX_W) - sum_ext + RND;

	always_comb begin
		if (t_c[T_W-1]) begin
			result = '0;
		end else if (|t_c[T_W-2:SH+PIX_W]) begin
			result = '1;
		end else begin
			result = t_c[SH+PIX_W-1:SH];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pixel_gamma_contrast_brightness_top.sv
`timescale 1ns / 1ps
`default_nettype none

// pixel gamma, contrast and brightness adjustment
// input channel: one request is one pixel of three 8-bit samples, taken at a rising
//   edge with pix_valid high and pix_stall low
// output channel: one request per pixel, the three adjusted samples, handed over at
//   a rising edge with res_valid high and res_stall low; order is kept
// configuration: cfg_we writes cfg_wdata into register cfg_index (0 gain,
//   1 gamma exponent, 2 brightness offset); an unused index is ignored
// the result passes each lane's table read, product and sum registers, then the output register
// throughput: one pixel per clock while pix_stall is low, three lanes working on the three samples
// a gamma write or reset rebuilds the 256-entry power table held in each lane;
//   pix_stall stays high meanwhile, as the serial square root unit forms every entry
// gain and offset writes take effect at once, no rebuild
// a stalled result holds in the output register while the pipe behind it keeps
//   filling; back-pressure raises pix_stall only once all stages are occupied
module pixel_gamma_contrast_brightness_top #(
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pgcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pgcb_pkg::REG_BITS-1:0]     cfg_wdata,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  pgcb_pkg::pix_t                    chan_first,
	input  pgcb_pkg::pix_t                    chan_second,
	input  pgcb_pkg::pix_t                    chan_third,
	output logic                              res_valid,
	input  logic                              res_stall,
	output pgcb_pkg::pix_t                    out_first,
	output pgcb_pkg::pix_t                    out_second,
	output pgcb_pkg::pix_t                    out_third
);
	import pgcb_pkg::*;

	localparam int GAIN_W = (COEF_FRAC_BITS + 1 > REG_BITS) ? COEF_FRAC_BITS + 1 : REG_BITS;
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1) << COEF_FRAC_BITS;
	// the exponent one, 1 << COEF_FRAC_BITS, resets to zero when it does not fit the register
	localparam int GAMMA_RST_I = (COEF_FRAC_BITS < REG_BITS) ? (1 << COEF_FRAC_BITS) : 0;
	localparam logic [REG_BITS-1:0] GAMMA_RST = REG_BITS'(GAMMA_RST_I);

	// configuration registers
	logic [GAIN_W-1:0]          gain_q;
	logic [REG_BITS-1:0]        gamma_q;
	logic signed [REG_BITS-1:0] bright_q;

	// pipe control
	logic    valid_s1;
	logic    valid_s2;
	logic    valid_s3;
	logic    res_valid_q;
	logic    en_o;
	adv_t    adv;
	logic    accept;
	logic    building;
	logic    rebuild;
	tbl_wr_t tbl_wr;

	// lane results and the merged output register
	pix_t    lane_first;
	pix_t    lane_second;
	pix_t    lane_third;
	pix_t    out_first_q;
	pix_t    out_second_q;
	pix_t    out_third_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			gamma_q  <= GAMMA_RST;
			bright_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONTRAST: gain_q   <= GAIN_W'(cfg_wdata);
				REG_GAMMA:    gamma_q  <= cfg_wdata;
				REG_BRIGHT:   bright_q <= signed'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	// a new exponent means a new power table
	assign rebuild = cfg_we && (cfg_index == REG_GAMMA);

	pgcb_table #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.gamma  (gamma_q),
		.rebuild(rebuild),
		.busy   (building),
		.tbl_wr (tbl_wr)
	);

	// each stage moves on when the one after it is empty or moving
	assign en_o    = !res_valid_q || !res_stall;
	assign adv.en3 = !valid_s3 || en_o;
	assign adv.en2 = !valid_s2 || adv.en3;
	assign adv.en1 = !valid_s1 || adv.en2;

	// hold off while the table fills, on a register write and while stage one is held
	assign pix_stall = building || !adv.en1 || cfg_we;
	assign accept    = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv.en1) begin
				valid_s1 <= accept;
			end
			if (adv.en2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.en3) begin
				valid_s3 <= valid_s2;
			end
			if (en_o) begin
				res_valid_q <= valid_s3;
			end
		end
	end

	pgcb_lane #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_lane_first (
		.clk   (clk),
		.adv   (adv),
		.tbl_wr(tbl_wr),
		.chan  (chan_first),
		.gain  (gain_q),
		.bright(bright_q),
		.result(lane_first)
	);

	pgcb_lane #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_lane_second (
		.clk   (clk),
		.adv   (adv),
		.tbl_wr(tbl_wr),
		.chan  (chan_second),
		.gain  (gain_q),
		.bright(bright_q),
		.result(lane_second)
	);

	pgcb_lane #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_lane_third (
		.clk   (clk),
		.adv   (adv),
		.tbl_wr(tbl_wr),
		.chan  (chan_third),
		.gain  (gain_q),
		.bright(bright_q),
		.result(lane_third)
	);

	// merge the three lanes into one output request
	always_ff @(posedge clk) begin
		if (en_o) begin
			out_first_q  <= lane_first;
			out_second_q <= lane_second;
			out_third_q  <= lane_third;
		end
	end

	assign res_valid  = res_valid_q;
	assign out_first  = out_first_q;
	assign out_second = out_second_q;
	assign out_third  = out_third_q;

	a_gamma_rebuilds : assert property (@(posedge clk) disable iff (!arst_n)
		rebuild |=> building)
		else $error("gamma write did not start a table rebuild");

	a_out_from_s3 : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s3))
		else $error("output request appeared without a finished stage three");

	a_s3_drains : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !res_valid_q) |=> res_valid_q)
		else $error("finished request did not enter the empty output register");

	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before stage one");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// testbench for the pixel gamma, contrast and brightness block
// a directed table runs first (reset identity, gain and offset extremes, zero to
// the zeroth, zero sample, out-of-range registers, ignored register index), then
// eight random phases each with fresh register settings. every result request is
// checked field by field against a typed value or a fixed-point transfer model
module testbench;
	import pgcb_pkg::*;

	localparam int FRAC = 8;
	localparam int PHASES = 8;
	localparam int PHASE_PIXELS = 200;

	// index that maps to no register, writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

	typedef struct packed {
		pix_t first;
		pix_t second;
		pix_t third;
	} pixel_t;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;

	typedef struct packed {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [REG_BITS-1:0]  data;
		pixel_t               pix;
		logic                 typed;
		pixel_t               want;
	} stim_row_t;

	// directed table: register writes and pixels, typed results only where obvious
	localparam int DIRECTED_ROWS = 29;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// reset settings are the identity transfer
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd255, 8'd128}, 1'b1, {8'd0, 8'd255, 8'd128}},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd1, 8'd254, 8'd127}, 1'b1, {8'd1, 8'd254, 8'd127}},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd85, 8'd170, 8'd15}, 1'b1, {8'd85, 8'd170, 8'd15}},
		// gain of two, saturates at the top
		'{ROW_WRITE, REG_CONTRAST, 10'd512, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd255, 8'd100}, 1'b1, {8'd0, 8'd255, 8'd200}},
		// offset of minus one, negative sums clamp to zero
		'{ROW_WRITE, REG_BRIGHT, 10'h300, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd255, 8'd0}, 1'b1, {8'd0, 8'd255, 8'd0}},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd64, 8'd192, 8'd128}, 1'b0, 24'd0},
		// write to an unused index changes nothing
		'{ROW_WRITE, REG_UNUSED, 10'h3ff, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd64, 8'd192, 8'd128}, 1'b0, 24'd0},
		// offset of plus one
		'{ROW_WRITE, REG_BRIGHT, 10'h100, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd128, 8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
		// zero gain, zero offset
		'{ROW_WRITE, REG_CONTRAST, 10'd0, 24'd0, 1'b0, 24'd0},
		'{ROW_WRITE, REG_BRIGHT, 10'd0, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd255, 8'd255, 8'd255}, 1'b1, 24'd0},
		// zero exponent: every sample, zero included, powers to one
		'{ROW_WRITE, REG_CONTRAST, 10'd256, 24'd0, 1'b0, 24'd0},
		'{ROW_WRITE, REG_GAMMA, 10'd0, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd0, 8'd0}, 1'b1, {8'd255, 8'd255, 8'd255}},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd17, 8'd255, 8'd200}, 1'b1, {8'd255, 8'd255, 8'd255}},
		// square law, zero sample stays zero
		'{ROW_WRITE, REG_GAMMA, 10'd512, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd255, 8'd0}, 1'b1, {8'd0, 8'd255, 8'd0}},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd128, 8'd64, 8'd200}, 1'b0, 24'd0},
		// out-of-range patterns: largest gain and exponent, most negative offset
		'{ROW_WRITE, REG_CONTRAST, 10'd1023, 24'd0, 1'b0, 24'd0},
		'{ROW_WRITE, REG_BRIGHT, 10'h200, 24'd0, 1'b0, 24'd0},
		'{ROW_WRITE, REG_GAMMA, 10'd1023, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd255, 8'd200}, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd1, 8'd100, 8'd254}, 1'b0, 24'd0},
		// largest positive offset saturates everything
		'{ROW_WRITE, REG_BRIGHT, 10'h1ff, 24'd0, 1'b0, 24'd0},
		'{ROW_PIXEL, REG_CONTRAST, 10'd0, {8'd0, 8'd1, 8'd2}, 1'b1, {8'd255, 8'd255, 8'd255}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_BITS-1:0] cfg_wdata = '0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t chan_first = '0;
	pix_t chan_second = '0;
	pix_t chan_third = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	pix_t out_first;
	pix_t out_second;
	pix_t out_third;

	// shadow of the block's registers, follows every write
	logic [REG_BITS-1:0] gain_set = 10'd256;
	logic [REG_BITS-1:0] gamma_set = 10'd256;
	logic signed [REG_BITS-1:0] bright_set = 10'sd0;

	// adjusted pixels still owed by the block, oldest first
	pixel_t pending_pixels[$];
	int mismatches = 0;

	// idling odds in percent, changed as the run moves on
	int send_gap_pct = 20;
	int recv_stall_pct = 87;

	always #5 clk = ~clk;

	pixel_gamma_contrast_brightness_top #(
		.COEF_FRAC_BITS(FRAC)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.chan_first (chan_first),
		.chan_second(chan_second),
		.chan_third (chan_third),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_first  (out_first),
		.out_second (out_second),
		.out_third  (out_third)
	);

	// floor of the square root, digit by digit
	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] rem, root, probe;
		rem = n;
		root = 64'd0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 64'd0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// q30 product, rounded half up
	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	// x to the power g / 2^FRAC: roots for the fraction bits, squares above them
	function automatic logic [63:0] q30_power(input logic [63:0] x,
	                                           input logic [REG_BITS-1:0] g);
		logic [63:0] acc, f;
		acc = 64'd1 << 30;
		for (int k = 0; k < REG_BITS; k++) begin
			if (g[k]) begin
				f = x;
				if (k < FRAC) begin
					for (int i = 0; i < FRAC - k; i++)
						f = floor_root(f << 30);
				end else begin
					for (int i = 0; i < k - FRAC; i++)
						f = q30_mul(f, f);
				end
				acc = q30_mul(acc, f);
			end
		end
		return acc;
	endfunction

	// one channel through gain * x^gamma + offset, rounded and clamped
	function automatic pix_t adjust_sample(input pix_t v);
		logic [63:0] x, p;
		longint sum, scaled;
		x = ((64'(v) << 30) + 64'd127) / 64'd255;
		p = q30_power(x, gamma_set);
		sum = longint'(p * 64'(gain_set)) + longint'(bright_set) * (longint'(1) << 30);
		scaled = sum * 255 + (longint'(1) << (29 + FRAC));
		if (scaled < 0)
			return 8'd0;
		if ((scaled >>> (30 + FRAC)) > 255)
			return 8'd255;
		return pix_t'(scaled >>> (30 + FRAC));
	endfunction

	function automatic pixel_t adjust_pixel(input pixel_t px);
		return {adjust_sample(px.first), adjust_sample(px.second), adjust_sample(px.third)};
	endfunction

	// register write, only once the pipe has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_BITS-1:0] data);
		pix_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_CONTRAST: gain_set = data;
			REG_GAMMA:    gamma_set = data;
			REG_BRIGHT:   bright_set = signed'(data);
			default: ;
		endcase
	endtask

	// one pixel request; the owed result is typed in or predicted at acceptance
	task automatic send_pixel(input pixel_t px, input logic typed, input pixel_t want);
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		chan_first <= px.first;
		chan_second <= px.second;
		chan_third <= px.third;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		pending_pixels.push_back(typed ? want : adjust_pixel(px));
	endtask

	function automatic pix_t random_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic check_field(input string name, input pix_t want, input pix_t got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// result side: random stall, every accepted request checked in order
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got %0d %0d %0d",
				         $time, out_first, out_second, out_third);
			end else begin
				check_field("out_first", pending_pixels[0].first, out_first);
				check_field("out_second", pending_pixels[0].second, out_second);
				check_field("out_third", pending_pixels[0].third, out_third);
				void'(pending_pixels.pop_front());
			end
		end
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin
		int sent;
		logic [REG_BITS-1:0] gain, bright;
		pixel_t px;

		// reset first; the power table rebuild after it holds pix_stall high
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_WRITE)
				write_reg(DIRECTED[r].idx, DIRECTED[r].data);
			else
				send_pixel(DIRECTED[r].pix, DIRECTED[r].typed, DIRECTED[r].want);
		end

		sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			// gain and offset: mostly in range, two phases pinned at the extremes
			gain = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
			                                   : 10'($urandom_range(0, 512));
			bright = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
			                                     : 10'($urandom_range(0, 512) - 256);
			if (ph == 0) begin
				gain = 10'd512;
				bright = 10'h300;
			end else if (ph == 1) begin
				gain = 10'd1023;
				bright = 10'h200;
			end
			write_reg(REG_CONTRAST, gain);
			write_reg(REG_BRIGHT, bright);
			// exponent only every other phase, each write costs a full table rebuild
			case (ph)
				0: write_reg(REG_GAMMA, 10'd128);
				2: write_reg(REG_GAMMA, 10'd1);
				4: write_reg(REG_GAMMA, 10'd767);
				6: write_reg(REG_GAMMA, 10'($urandom_range(0, 1023)));
				7: write_reg(REG_UNUSED, 10'($urandom_range(0, 1023)));
				default: ;
			endcase

			for (int i = 0; i < PHASE_PIXELS; i++) begin
				// receiver stalls first, then the sender idles, then neither
				if (sent == PHASES * PHASE_PIXELS / 3) begin
					send_gap_pct = 87;
					recv_stall_pct = 20;
				end else if (sent == 2 * PHASES * PHASE_PIXELS / 3) begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				px = {random_sample(), random_sample(), random_sample()};
				send_pixel(px, 1'b0, 24'd0);
				sent++;
			end
		end

		// drain, then wait for anything stray
		cfg_we <= 1'b0;
		pix_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog, well beyond the slowest run including every table rebuild
	initial begin
		#50000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pgcb_pkg.sv
rtl/pgcb_ram.sv
rtl/pgcb_isqrt.sv
rtl/pgcb_table.sv
rtl/pgcb_lane.sv
rtl/pixel_gamma_contrast_brightness_top.sv
verif/testbench.sv
